FILE: design/lpps_pkg.sv
// ============================================================================
// lpps_pkg: shared types and constants for the line position steering block
// Holds the register map, the configuration bundle and the fixed thresholds.
// ============================================================================
package lpps_pkg;

  // Configuration port geometry.
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int INDEX_BITS = 3;

  // Register indexes, byte address is four times the index.
  localparam logic [INDEX_BITS-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_DUTY_NOM = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_DUTY_LO  = 3'd4;
  localparam logic [INDEX_BITS-1:0] REG_DUTY_HI  = 3'd5;

  localparam int GAIN_BITS = 16;
  localparam int PCT_BITS = 7;
  localparam int DUTY_BITS = 15;

  localparam logic [PCT_BITS-1:0] RESET_DUTY_NOM = 7'd56;
  localparam logic [PCT_BITS-1:0] RESET_DUTY_LO  = 7'd46;
  localparam logic [PCT_BITS-1:0] RESET_DUTY_HI  = 7'd66;

  // Sensor thresholds and control constants.
  localparam int MARGIN_BLACK = 400;
  localparam int MARGIN_WHITE = 2000;
  localparam int INTEGRAL_LIMIT = 30;
  localparam int ERROR_SCALE = 10;
  localparam int LOST_ERROR_X10 = 25;
  // The inverted map scales 0..1600 onto 0..1000, which is exactly 5/8.
  localparam int MAP_SHIFT = 3;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain_proportional;
    logic [GAIN_BITS-1:0] gain_integral;
    logic [GAIN_BITS-1:0] gain_derivative;
    logic [PCT_BITS-1:0]  duty_nominal;
    logic [PCT_BITS-1:0]  duty_floor;
    logic [PCT_BITS-1:0]  duty_ceiling;
  } cfg_t;

endpackage

FILE: design/lpps_cfg.sv
// ============================================================================
// lpps_cfg: configuration register file
// APB-style write and read access to the gains and the duty limits.
// ============================================================================
module lpps_cfg
  import lpps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [INDEX_BITS-1:0] index;
  logic                  wr_en;

  assign index  = paddr[ADDR_BITS-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_proportional <= '0;
      cfg.gain_integral     <= '0;
      cfg.gain_derivative   <= '0;
      cfg.duty_nominal      <= RESET_DUTY_NOM;
      cfg.duty_floor        <= RESET_DUTY_LO;
      cfg.duty_ceiling      <= RESET_DUTY_HI;
    end else if (wr_en) begin
      unique case (index)
        REG_GAIN_P:   cfg.gain_proportional <= pwdata[GAIN_BITS-1:0];
        REG_GAIN_I:   cfg.gain_integral     <= pwdata[GAIN_BITS-1:0];
        REG_GAIN_D:   cfg.gain_derivative   <= pwdata[GAIN_BITS-1:0];
        REG_DUTY_NOM: cfg.duty_nominal      <= pwdata[PCT_BITS-1:0];
        REG_DUTY_LO:  cfg.duty_floor        <= pwdata[PCT_BITS-1:0];
        REG_DUTY_HI:  cfg.duty_ceiling      <= pwdata[PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_GAIN_P:   prdata = DATA_BITS'(cfg.gain_proportional);
      REG_GAIN_I:   prdata = DATA_BITS'(cfg.gain_integral);
      REG_GAIN_D:   prdata = DATA_BITS'(cfg.gain_derivative);
      REG_DUTY_NOM: prdata = DATA_BITS'(cfg.duty_nominal);
      REG_DUTY_LO:  prdata = DATA_BITS'(cfg.duty_floor);
      REG_DUTY_HI:  prdata = DATA_BITS'(cfg.duty_ceiling);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: design/lpps_div.sv
// ============================================================================
// lpps_div: bit-serial unsigned divider
// Restoring division that produces one quotient bit per clock cycle.
// ============================================================================
module lpps_div
  import lpps_pkg::*;
#(
  parameter int SENSOR_BITS = 12,
  parameter int FRAC_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [SENSOR_BITS+8+FRAC_BITS-1:0]       dividend,
  input  logic [SENSOR_BITS+2-1:0]                 divisor,
  output logic [FRAC_BITS+6-1:0]                   quotient,
  output logic                                     done
);

  localparam int SW = SENSOR_BITS + 2;
  localparam int QW = FRAC_BITS + 6;
  localparam int DW = SENSOR_BITS + 8 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  // The quotient is known to fit in QW bits, so the upper dividend bits are
  // already below the divisor and start out as the partial remainder.
  logic [SW-1:0] rem;
  logic [QW-1:0] qsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [SW:0]   trial;
  logic          take;

  assign trial    = {rem, qsh[QW-1]} - {1'b0, divisor};
  assign take     = ~trial[SW];
  assign quotient = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DW-1:QW];
      qsh <= dividend[QW-1:0];
    end else if (busy) begin
      if (take) begin
        rem <= trial[SW-1:0];
      end else begin
        rem <= {rem[SW-2:0], qsh[QW-1]};
      end
      qsh <= {qsh[QW-2:0], take};
    end
  end

endmodule

FILE: design/lpps_mac.sv
// ============================================================================
// lpps_mac: bit-serial PID multiply-accumulate
// Walks the three gains most significant bit first, one bit per cycle.
// ============================================================================
module lpps_mac
  import lpps_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  cfg_t                              cfg,
  input  logic signed [FRAC_BITS+7-1:0]     err,
  input  logic signed [FRAC_BITS+7-1:0]     integ,
  input  logic signed [FRAC_BITS+8-1:0]     diff,
  output logic signed [FRAC_BITS+26-1:0]    acc,
  output logic                              done
);

  localparam int AW = FRAC_BITS + 26;
  localparam int BW = $clog2(GAIN_BITS);

  logic [BW-1:0]        bit_idx;
  logic                 busy;
  logic signed [AW-1:0] t_p;
  logic signed [AW-1:0] t_i;
  logic signed [AW-1:0] t_d;

  always_comb begin
    t_p = cfg.gain_proportional[bit_idx] ? AW'(err) : '0;
    t_i = cfg.gain_integral[bit_idx] ? AW'(integ) : '0;
    t_d = cfg.gain_derivative[bit_idx] ? AW'(diff) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_idx <= '0;
    end else begin
      done <= !start && busy && (bit_idx == '0);
      if (start) begin
        busy    <= 1'b1;
        bit_idx <= BW'(GAIN_BITS - 1);
      end else if (busy) begin
        bit_idx <= bit_idx - BW'(1);
        if (bit_idx == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (busy) begin
      acc <= (acc <<< 1) + t_p + t_i + t_d;
    end
  end

endmodule

FILE: design/line_position_pid_steering.sv
// ============================================================================
// line_position_pid_steering: line follower steering controller
// Weighted-average line position from four sensors, PID correction, duties.
// ============================================================================
// Each request carries four sensor samples of one control tick and yields one
// result with the left and right motor duty cycles in Q8.8 percent, plus flags
// for the inverted line pattern and for a lost line. The block handles one
// request at a time. The time from acceptance to a valid result is set by
// the bit-serial divider, which forms the line position bit by bit, and by
// the bit-serial multiply-accumulate, which walks the gain bits in turn.
// When the line is lost or the sensor sum is zero the divider is skipped and
// the request finishes sooner. A finished result sits in an output register,
// so a new request is accepted as soon as the result has been loaded there,
// even if it is still waiting to be taken. Gains and duty limits are written
// through the APB-style port at byte addresses 0, 4, 8, 12, 16 and 20 and
// should only change while the block is idle.
module line_position_pid_steering
  import lpps_pkg::*;
#(
  parameter int SENSOR_BITS = 12,
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   pready,
  // Request channel.
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SENSOR_BITS-1:0] sensor_a,
  input  logic [SENSOR_BITS-1:0] sensor_b,
  input  logic [SENSOR_BITS-1:0] sensor_c,
  input  logic [SENSOR_BITS-1:0] sensor_d,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DUTY_BITS-1:0]   left_duty,
  output logic [DUTY_BITS-1:0]   right_duty,
  output logic                   inverted_seen,
  output logic                   line_lost
);

  // Sample width wide enough to compare against the 2000 threshold.
  localparam int XW = (SENSOR_BITS > 11) ? SENSOR_BITS : 11;
  // Signed weighted sum, plain sum and divider widths.
  localparam int WW = SENSOR_BITS + 5;
  localparam int SW = SENSOR_BITS + 2;
  localparam int MW = SENSOR_BITS + 8;
  localparam int DW = MW + FRAC_BITS;
  localparam int QW = FRAC_BITS + 6;
  // Error and integral, and the wider difference and integral sum.
  localparam int EW = FRAC_BITS + 7;
  localparam int IW = FRAC_BITS + 8;
  // Accumulator of the PID sum.
  localparam int AW = FRAC_BITS + 26;
  // Conversion of Q.FRAC_BITS to Q8.8.
  localparam int SHR = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int SHL = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;

  localparam logic signed [EW-1:0] LOST_POS = EW'(LOST_ERROR_X10 << FRAC_BITS);
  localparam logic signed [EW-1:0] LOST_NEG = -LOST_POS;
  localparam logic signed [IW-1:0] ILIM_POS = IW'(INTEGRAL_LIMIT << FRAC_BITS);
  localparam logic signed [IW-1:0] ILIM_NEG = -ILIM_POS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_MAC  = 3'd5;
  localparam logic [2:0] S_CORR = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  cfg_t cfg;

  logic [2:0] state;

  // Request samples as accepted, then as used by the position estimate.
  logic [SENSOR_BITS-1:0] s_raw [4];
  logic [XW-1:0]          s_use [4];
  logic                   inv;
  logic                   lost;

  // Front-end combinational results.
  logic [XW-1:0]     sx [4];
  logic [XW-1:0]     sclamp [4];
  logic [XW-1:0]     soff [4];
  logic [12:0]       smul5 [4];
  logic [XW-1:0]     smap [4];
  logic              inv_now;
  logic              lost_now;
  logic signed [WW-1:0] wa;
  logic signed [WW-1:0] wb;
  logic signed [WW-1:0] wc;
  logic signed [WW-1:0] wd;
  logic signed [WW-1:0] wsum;
  logic [WW-1:0]        sum_full;
  logic [SW-1:0]        sum_now;
  logic [WW-1:0]        wmag_full;
  logic [MW-1:0]        wmag10;

  // Divider interface.
  logic            div_go;
  logic [DW-1:0]   dividend;
  logic [SW-1:0]   divisor;
  logic            quo_neg;
  logic [QW-1:0]   quotient;
  logic            div_done;

  // Controller state and PID operands.
  logic signed [EW-1:0] err;
  logic signed [EW-1:0] last_error;
  logic signed [EW-1:0] error_integral;
  logic signed [IW-1:0] diff;
  logic signed [IW-1:0] isum;
  logic signed [IW-1:0] iclamp;
  logic signed [EW-1:0] quo_signed;

  logic                 mac_go;
  logic signed [AW-1:0] acc;
  logic                 mac_done;

  // Duty computation.
  logic signed [AW-1:0] corr;
  logic signed [AW-1:0] nom;
  logic signed [AW-1:0] duty_lo;
  logic signed [AW-1:0] duty_hi;
  logic signed [AW-1:0] left_raw;
  logic signed [AW-1:0] right_raw;

  function automatic logic [DUTY_BITS-1:0] clamp_to_q88(
    input logic signed [AW-1:0] v,
    input logic signed [AW-1:0] lo,
    input logic signed [AW-1:0] hi
  );
    logic signed [AW-1:0] c;
    logic [AW-1:0]        u;
    c = v;
    if (v < lo) begin
      c = lo;
    end else if (v > hi) begin
      c = hi;
    end
    u = (c < 0) ? '0 : AW'(c);
    u = (u >> SHR) << SHL;
    return u[DUTY_BITS-1:0];
  endfunction

  lpps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpps_div #(
    .SENSOR_BITS (SENSOR_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  lpps_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_go),
    .cfg   (cfg),
    .err   (err),
    .integ (error_integral),
    .diff  (diff),
    .acc   (acc),
    .done  (mac_done)
  );

  assign in_ready = (state == S_IDLE);

  // Inverted pattern detection and the clamp-and-map of every sample. The
  // mapping (s - 400) * 1000 / 1600 reduces to (s - 400) * 5 >> 3.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sx[i] = XW'(s_raw[i]);
      if (sx[i] < XW'(MARGIN_BLACK)) begin
        sclamp[i] = XW'(MARGIN_BLACK);
      end else if (sx[i] > XW'(MARGIN_WHITE)) begin
        sclamp[i] = XW'(MARGIN_WHITE);
      end else begin
        sclamp[i] = sx[i];
      end
      soff[i]  = sclamp[i] - XW'(MARGIN_BLACK);
      smul5[i] = {soff[i][10:0], 2'b00} + 13'(soff[i][10:0]);
      smap[i]  = XW'(smul5[i][12:MAP_SHIFT]);
    end
    inv_now = (sx[0] > XW'(MARGIN_WHITE)) && (sx[1] < XW'(MARGIN_WHITE)) &&
              (sx[2] < XW'(MARGIN_WHITE)) && (sx[3] > XW'(MARGIN_WHITE));
    lost_now = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ((inv_now ? smap[i] : sx[i]) > XW'(MARGIN_BLACK)) begin
        lost_now = 1'b0;
      end
    end
  end

  // Weighted sum with weights 3,1,-1,-3, or -2,-5,5,2 in inverted mode.
  always_comb begin
    wa = signed'(WW'(s_use[0]));
    wb = signed'(WW'(s_use[1]));
    wc = signed'(WW'(s_use[2]));
    wd = signed'(WW'(s_use[3]));
    if (inv) begin
      wsum = ((wd - wa) <<< 1) + ((wc - wb) <<< 2) + (wc - wb);
    end else begin
      wsum = ((wa - wd) <<< 1) + (wa - wd) + (wb - wc);
    end
    sum_full  = WW'(s_use[0]) + WW'(s_use[1]) + WW'(s_use[2]) + WW'(s_use[3]);
    sum_now   = sum_full[SW-1:0];
    wmag_full = (wsum < 0) ? WW'(-wsum) : WW'(wsum);
    wmag10    = {wmag_full[MW-5:0], 3'b000} + MW'({wmag_full[MW-5:0], 1'b0});
  end

  // Signed quotient, and the integral update with its symmetric clamp.
  always_comb begin
    quo_signed = quo_neg ? -signed'(EW'(quotient)) : signed'(EW'(quotient));
    isum       = IW'(error_integral) + IW'(err);
    if (isum < ILIM_NEG) begin
      iclamp = ILIM_NEG;
    end else if (isum > ILIM_POS) begin
      iclamp = ILIM_POS;
    end else begin
      iclamp = isum;
    end
  end

  // Duty limits in Q.FRAC_BITS; the correction is the PID sum shifted right by 8 bits, floored.
  always_comb begin
    corr    = acc >>> 8;
    nom     = signed'(AW'({cfg.duty_nominal, {FRAC_BITS{1'b0}}}));
    duty_lo = signed'(AW'({cfg.duty_floor, {FRAC_BITS{1'b0}}}));
    duty_hi = signed'(AW'({cfg.duty_ceiling, {FRAC_BITS{1'b0}}}));
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      div_go         <= 1'b0;
      mac_go         <= 1'b0;
      out_valid      <= 1'b0;
      last_error     <= '0;
      error_integral <= '0;
    end else begin
      div_go <= (state == S_SUM) && !(lost || (sum_now == '0));
      mac_go <= (state == S_UPD);
      // The output register frees up in the same cycle it is taken.
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (lost || (sum_now == '0)) begin
            state <= S_UPD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          error_integral <= iclamp[EW-1:0];
          last_error     <= err;
          state          <= S_MAC;
        end
        S_MAC: begin
          if (mac_done) begin
            state <= S_CORR;
          end
        end
        S_CORR: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      s_raw[0] <= sensor_a;
      s_raw[1] <= sensor_b;
      s_raw[2] <= sensor_c;
      s_raw[3] <= sensor_d;
    end
    if (state == S_MAP) begin
      for (int i = 0; i < 4; i++) begin
        s_use[i] <= inv_now ? smap[i] : sx[i];
      end
      inv  <= inv_now;
      lost <= lost_now;
    end
    if (state == S_SUM) begin
      dividend <= {wmag10, {FRAC_BITS{1'b0}}};
      divisor  <= sum_now;
      quo_neg  <= (wsum < 0);
      if (lost) begin
        err <= (last_error > 0) ? LOST_POS : LOST_NEG;
      end else begin
        err <= '0;
      end
    end
    if ((state == S_DIV) && div_done) begin
      err <= quo_signed;
    end
    if (state == S_UPD) begin
      diff <= IW'(err) - IW'(last_error);
    end
    if (state == S_CORR) begin
      left_raw  <= nom - corr;
      right_raw <= nom + corr;
    end
    if ((state == S_FIN) && (!out_valid || out_ready)) begin
      left_duty     <= clamp_to_q88(left_raw, duty_lo, duty_hi);
      right_duty    <= clamp_to_q88(right_raw, duty_lo, duty_hi);
      inverted_seen <= inv;
      line_lost     <= lost;
    end
  end

endmodule
